FILE: design/spfb_pkg.sv
// ----------------------------------------------------------------------------
// spfb_pkg: shared types and constants for the serial program frame builder
// Command codes, instruction opcodes and the descriptor passed from the
// front end to the byte sequencer.
// ----------------------------------------------------------------------------
package spfb_pkg;

    typedef enum logic [3:0] {
        CMD_READ_FLASH  = 4'd0,
        CMD_LOAD_FLASH  = 4'd1,
        CMD_WRITE_PAGE  = 4'd2,
        CMD_READ_EEPROM = 4'd3,
        CMD_WRITE_EEP   = 4'd4,
        CMD_CHIP_ERASE  = 4'd5,
        CMD_FUSE_LOW    = 4'd6,
        CMD_FUSE_HIGH   = 4'd7,
        CMD_ENTER_PROG  = 4'd8
    } cmd_t;

    localparam logic [7:0] OP_LOAD_EXT   = 8'h4D;
    localparam logic [7:0] OP_READ_FLASH = 8'h20;
    localparam logic [7:0] OP_LOAD_FLASH = 8'h40;
    localparam logic [7:0] OP_WRITE_PAGE = 8'h4C;
    localparam logic [7:0] OP_READ_EEP   = 8'hA0;
    localparam logic [7:0] OP_WRITE_EEP  = 8'hC0;
    localparam logic [7:0] OP_PROG       = 8'hAC;
    localparam logic [7:0] SUB_ERASE     = 8'h80;
    localparam logic [7:0] SUB_FUSE_LOW  = 8'hA0;
    localparam logic [7:0] SUB_FUSE_HIGH = 8'hA8;
    localparam logic [7:0] SUB_ENABLE    = 8'h53;

    localparam int          EXT_LSB     = 17;
    localparam logic [3:0]  WAIT_LONG   = 4'd10;
    localparam logic [3:0]  WAIT_FUSE   = 4'd5;
    localparam logic [2:0]  IDX_FIRST   = 3'd0;
    localparam logic [2:0]  IDX_INSTR   = 3'd4;
    localparam logic [2:0]  IDX_FINAL   = 3'd7;

    // One queued command, fully decoded
    typedef struct packed {
        logic [2:0]      start_idx;  // 0 with extended frame, 4 without
        logic [7:0]      ext_byte;
        logic [3:0][7:0] instr;      // instruction bytes, index 0 sent first
        logic            cap_en;
        logic [1:0]      cap_idx;
        logic [3:0]      wait_ms;
    } desc_t;

    // Queue status seen by the sequencer
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } head_t;

endpackage

FILE: design/avr_serial_program_frame_builder.sv
// ----------------------------------------------------------------------------
// avr_serial_program_frame_builder: serial programming instruction encoder
// Turns programming commands into runs of SPI bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser holds the command code,
//   tdata the address, data byte and poll flag. m_axis returns the SPI
//   bytes of that command's instruction, one per beat, with tlast on the
//   final byte. tdata on m_axis holds the byte, the capture flag and the
//   wait in milliseconds (nonzero only on the last byte).
//   Flash commands whose address bits 24..17 leave the tracked page window
//   first get a four-byte load-extended-address frame: eight bytes in all,
//   other commands four. Unused command codes are dropped with no output.
//   A command is registered in the descriptor queue, then its first byte
//   in the sequencer's output register. The byte sequencer emits one byte
//   per cycle while m_axis_tready stays high; a two-entry descriptor queue
//   lets the decoder take new commands while a run is still going out.
//   Reset clears the tracked extended byte to zero and empties the queue.
//   When m_axis_tready is low the output beat holds, the sequencer stops,
//   and s_axis_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module avr_serial_program_frame_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // address[24:0], data[32:25], poll_wait[33], zero pad
    input  logic [3:0]  s_axis_tuser,   // command[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // spi_byte[7:0], capture[8], wait_ms[12:9], zero pad
    output logic        m_axis_tlast    // last
);

    logic             accept;
    logic             push;
    spfb_pkg::desc_t  push_desc;
    logic             pop;
    logic             full;
    spfb_pkg::head_t  head;
    logic [7:0]       out_byte;
    logic             out_cap;
    logic [3:0]       out_wait;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    spfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .command   (s_axis_tuser),
        .address   (s_axis_tdata[24:0]),
        .data      (s_axis_tdata[32:25]),
        .poll_wait (s_axis_tdata[33]),
        .push      (push),
        .push_desc (push_desc)
    );

    spfb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (full),
        .head      (head)
    );

    spfb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_byte    (out_byte),
        .m_capture (out_cap),
        .m_wait    (out_wait),
        .m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, out_wait, out_cap, out_byte};

    // Wait time only rides on the final byte of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> (out_wait == 4'd0))
        else $error("wait_ms set on a byte that is not last");

    // A descriptor is retired only while one is present
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    // The queue never takes a descriptor while it is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    // After reset the input side is ready and no beat is pending
    assert property (@(posedge aclk)
        !aresetn |=> (s_axis_tready && !m_axis_tvalid))
        else $error("block not idle after reset");

endmodule

FILE: design/spfb_front.sv
// ----------------------------------------------------------------------------
// spfb_front: command decoder
// Accepts commands, tracks the extended address byte and builds a descriptor
// for each valid command. Unused command codes are dropped.
// ----------------------------------------------------------------------------
module spfb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [3:0]          command,
    input  logic [24:0]         address,
    input  logic [7:0]          data,
    input  logic                poll_wait,
    output logic                push,
    output spfb_pkg::desc_t     push_desc
);

    logic [7:0] ext_byte_reg;
    logic [7:0] ext_byte_next;
    logic [7:0] hi;
    logic       is_flash;
    logic       cmd_ok;

    assign hi = address[spfb_pkg::EXT_LSB +: 8];

    always_comb begin
        is_flash  = 1'b0;
        cmd_ok    = 1'b1;
        push_desc = '0;
        push_desc.start_idx = spfb_pkg::IDX_INSTR;
        push_desc.ext_byte  = hi;
        case (command)
            spfb_pkg::CMD_READ_FLASH, spfb_pkg::CMD_LOAD_FLASH,
            spfb_pkg::CMD_WRITE_PAGE: begin
                is_flash = 1'b1;
                push_desc.instr[1] = address[16:9];
                push_desc.instr[2] = address[8:1];
                if (command == spfb_pkg::CMD_READ_FLASH) begin
                    push_desc.instr[0] = spfb_pkg::OP_READ_FLASH | {4'd0, address[0], 3'd0};
                    push_desc.cap_en   = 1'b1;
                    push_desc.cap_idx  = 2'd3;
                end else if (command == spfb_pkg::CMD_LOAD_FLASH) begin
                    push_desc.instr[0] = spfb_pkg::OP_LOAD_FLASH | {4'd0, address[0], 3'd0};
                    push_desc.instr[3] = data;
                    push_desc.wait_ms  = {3'd0, poll_wait};
                end else begin
                    push_desc.instr[0] = spfb_pkg::OP_WRITE_PAGE;
                    push_desc.wait_ms  = {3'd0, poll_wait};
                end
            end
            spfb_pkg::CMD_READ_EEPROM: begin
                push_desc.instr[0] = spfb_pkg::OP_READ_EEP;
                push_desc.instr[1] = address[15:8];
                push_desc.instr[2] = address[7:0];
                push_desc.cap_en   = 1'b1;
                push_desc.cap_idx  = 2'd3;
            end
            spfb_pkg::CMD_WRITE_EEP: begin
                push_desc.instr[0] = spfb_pkg::OP_WRITE_EEP;
                push_desc.instr[1] = address[15:8];
                push_desc.instr[2] = address[7:0];
                push_desc.instr[3] = data;
                push_desc.wait_ms  = spfb_pkg::WAIT_LONG;
            end
            spfb_pkg::CMD_CHIP_ERASE: begin
                push_desc.instr[0] = spfb_pkg::OP_PROG;
                push_desc.instr[1] = spfb_pkg::SUB_ERASE;
                push_desc.wait_ms  = spfb_pkg::WAIT_LONG;
            end
            spfb_pkg::CMD_FUSE_LOW, spfb_pkg::CMD_FUSE_HIGH: begin
                push_desc.instr[0] = spfb_pkg::OP_PROG;
                push_desc.instr[1] = (command == spfb_pkg::CMD_FUSE_LOW)
                                   ? spfb_pkg::SUB_FUSE_LOW : spfb_pkg::SUB_FUSE_HIGH;
                push_desc.instr[3] = data;
                push_desc.wait_ms  = spfb_pkg::WAIT_FUSE;
            end
            spfb_pkg::CMD_ENTER_PROG: begin
                push_desc.instr[0] = spfb_pkg::OP_PROG;
                push_desc.instr[1] = spfb_pkg::SUB_ENABLE;
                push_desc.cap_en   = 1'b1;
                push_desc.cap_idx  = 2'd2;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
        // prepend the extended frame when the flash page window moves
        if (is_flash && (hi != ext_byte_reg)) begin
            push_desc.start_idx = spfb_pkg::IDX_FIRST;
        end
    end

    assign push          = accept && cmd_ok;
    assign ext_byte_next = (accept && is_flash) ? hi : ext_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_byte_reg <= 8'd0;
        end else begin
            ext_byte_reg <= ext_byte_next;
        end
    end

endmodule

FILE: design/spfb_queue.sv
// ----------------------------------------------------------------------------
// spfb_queue: two-entry descriptor queue
// Decouples the decoder from the byte sequencer.
// ----------------------------------------------------------------------------
module spfb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  spfb_pkg::desc_t     push_desc,
    input  logic                pop,
    output logic                full,
    output spfb_pkg::head_t     head
);

    spfb_pkg::desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.desc  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/spfb_back.sv
// ----------------------------------------------------------------------------
// spfb_back: byte sequencer
// Walks the head descriptor one SPI byte per beat into the output register,
// first the optional extended frame, then the four instruction bytes.
// ----------------------------------------------------------------------------
module spfb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  spfb_pkg::head_t     head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_byte,
    output logic                m_capture,
    output logic [3:0]          m_wait,
    output logic                m_last
);

    logic       active_reg, active_next;
    logic [2:0] idx_reg,    idx_next;
    logic       valid_reg,  valid_next;
    logic [7:0] byte_reg,   byte_next;
    logic       cap_reg,    cap_next;
    logic [3:0] wait_reg,   wait_next;
    logic       last_reg,   last_next;
    logic       load;
    logic [2:0] cur;

    assign load = !valid_reg || m_ready;
    assign cur  = active_reg ? idx_reg : head.desc.start_idx;

    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        cap_next    = cap_reg;
        wait_next   = wait_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                if (cur[2]) begin
                    byte_next = head.desc.instr[cur[1:0]];
                end else begin
                    case (cur[1:0])
                        2'd0:    byte_next = spfb_pkg::OP_LOAD_EXT;
                        2'd2:    byte_next = head.desc.ext_byte;
                        default: byte_next = 8'd0;
                    endcase
                end
                cap_next  = cur[2] && head.desc.cap_en && (cur[1:0] == head.desc.cap_idx);
                last_next = (cur == spfb_pkg::IDX_FINAL);
                wait_next = last_next ? head.desc.wait_ms : 4'd0;
                // advance, or retire the descriptor on its final byte
                if (last_next) begin
                    pop         = 1'b1;
                    active_next = 1'b0;
                end else begin
                    active_next = 1'b1;
                    idx_next    = cur + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        cap_reg  <= cap_next;
        wait_reg <= wait_next;
        last_reg <= last_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    assign m_valid   = valid_reg;
    assign m_byte    = byte_reg;
    assign m_capture = cap_reg;
    assign m_wait    = wait_reg;
    assign m_last    = last_reg;

endmodule

FILE: test/avr_serial_program_frame_builder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// avr_serial_program_frame_builder_test: self-checking bench for the builder
// Sends programming commands on s_axis and compares every SPI byte on m_axis
// against a local encoder that tracks the extended address window. Covers
// directed corner cases, then random well-formed commands with some unused
// codes mixed in, under random sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module avr_serial_program_frame_builder_test;

    localparam int RANDOM_CMDS  = 125;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int NO_CAPTURE   = 4;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [7:0] spi_byte;
        logic       capture;
        logic [3:0] wait_ms;
        logic       last;
    } spi_beat_t;

    class SpiRunTracker;
        spi_beat_t  expected_beats[$];
        logic [7:0] ext_window;
        int         fail_count;

        function new();
            ext_window = 8'h00;
            fail_count = 0;
        endfunction

        function void push_beat(logic [7:0] b, logic cap, logic [3:0] w, logic lst);
            spi_beat_t beat;
            beat.spi_byte = b;
            beat.capture  = cap;
            beat.wait_ms  = w;
            beat.last     = lst;
            expected_beats.push_back(beat);
        endfunction

        // Encode one accepted command into the SPI bytes it should produce
        function void note_command(logic [3:0] code, logic [24:0] addr, logic [7:0] data,
                                   logic poll);
            logic [7:0]      instr [4];
            logic [7:0]      window;
            logic [3:0]      w;
            int              cap_at;
            spfb_pkg::cmd_t  cmd;
            if (code > spfb_pkg::CMD_ENTER_PROG)
                return;
            cmd    = spfb_pkg::cmd_t'(code);
            cap_at = NO_CAPTURE;
            w      = 4'd0;
            case (cmd)
                spfb_pkg::CMD_READ_FLASH, spfb_pkg::CMD_LOAD_FLASH,
                spfb_pkg::CMD_WRITE_PAGE: begin
                    window = addr[24:spfb_pkg::EXT_LSB];
                    if (window != ext_window) begin
                        ext_window = window;
                        push_beat(spfb_pkg::OP_LOAD_EXT, 1'b0, 4'd0, 1'b0);
                        push_beat(8'h00, 1'b0, 4'd0, 1'b0);
                        push_beat(window, 1'b0, 4'd0, 1'b0);
                        push_beat(8'h00, 1'b0, 4'd0, 1'b0);
                    end
                    instr[1] = addr[16:9];
                    instr[2] = addr[8:1];
                    if (cmd == spfb_pkg::CMD_READ_FLASH) begin
                        instr[0] = spfb_pkg::OP_READ_FLASH | {4'b0, addr[0], 3'b0};
                        instr[3] = 8'h00;
                        cap_at   = 3;
                    end else if (cmd == spfb_pkg::CMD_LOAD_FLASH) begin
                        instr[0] = spfb_pkg::OP_LOAD_FLASH | {4'b0, addr[0], 3'b0};
                        instr[3] = data;
                        w        = {3'b0, poll};
                    end else begin
                        instr[0] = spfb_pkg::OP_WRITE_PAGE;
                        instr[3] = 8'h00;
                        w        = {3'b0, poll};
                    end
                end
                spfb_pkg::CMD_READ_EEPROM, spfb_pkg::CMD_WRITE_EEP: begin
                    instr[0] = (cmd == spfb_pkg::CMD_READ_EEPROM)
                             ? spfb_pkg::OP_READ_EEP : spfb_pkg::OP_WRITE_EEP;
                    instr[1] = addr[15:8];
                    instr[2] = addr[7:0];
                    if (cmd == spfb_pkg::CMD_READ_EEPROM) begin
                        instr[3] = 8'h00;
                        cap_at   = 3;
                    end else begin
                        instr[3] = data;
                        w        = spfb_pkg::WAIT_LONG;
                    end
                end
                default: begin
                    instr[0] = spfb_pkg::OP_PROG;
                    instr[2] = 8'h00;
                    case (cmd)
                        spfb_pkg::CMD_CHIP_ERASE: begin
                            instr[1] = spfb_pkg::SUB_ERASE;
                            instr[3] = 8'h00;
                            w        = spfb_pkg::WAIT_LONG;
                        end
                        spfb_pkg::CMD_FUSE_LOW: begin
                            instr[1] = spfb_pkg::SUB_FUSE_LOW;
                            instr[3] = data;
                            w        = spfb_pkg::WAIT_FUSE;
                        end
                        spfb_pkg::CMD_FUSE_HIGH: begin
                            instr[1] = spfb_pkg::SUB_FUSE_HIGH;
                            instr[3] = data;
                            w        = spfb_pkg::WAIT_FUSE;
                        end
                        default: begin
                            instr[1] = spfb_pkg::SUB_ENABLE;
                            instr[3] = 8'h00;
                            cap_at   = 2;
                        end
                    endcase
                end
            endcase
            for (int i = 0; i < 4; i++)
                push_beat(instr[i], i == cap_at, (i == 3) ? w : 4'd0, i == 3);
        endfunction

        function void check_beat(logic [15:0] tdata, logic tlast);
            spi_beat_t exp;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: spi_byte %h tlast %b", tdata[7:0], tlast);
                fail_count++;
                return;
            end
            exp = expected_beats.pop_front();
            if (tdata[7:0] !== exp.spi_byte) begin
                $error("spi_byte: expected %h, got %h", exp.spi_byte, tdata[7:0]);
                fail_count++;
            end
            if (tdata[8] !== exp.capture) begin
                $error("capture: expected %b, got %b", exp.capture, tdata[8]);
                fail_count++;
            end
            if (tdata[12:9] !== exp.wait_ms) begin
                $error("wait_ms: expected %0d, got %0d", exp.wait_ms, tdata[12:9]);
                fail_count++;
            end
            if (tlast !== exp.last) begin
                $error("last: expected %b, got %b", exp.last, tlast);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    SpiRunTracker tracker = new();

    int   cycle_count = 0;
    int   burst_left = 0;
    int   hold_left = 0;
    bit   hold_req = 1'b0;
    logic rdy_next;

    avr_serial_program_frame_builder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: check each beat, then pick the next tready from the current
    // stall mode; a requested hold-off keeps tready low for a long stretch
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_beat(m_axis_tdata, m_axis_tlast);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rdy_next  = 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            rdy_next  = 1'b0;
        end else begin
            case ((cycle_count / 64) % 4)
                0: rdy_next = 1'b1;
                1: rdy_next = 1'($urandom_range(0, 1));
                2: rdy_next = ($urandom_range(0, 3) != 0);
                default: rdy_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_axis_tready <= rdy_next;
    end

    // Offer one command; tvalid stays high afterwards unless a gap follows
    task automatic send_cmd(logic [3:0] code, logic [24:0] addr, logic [7:0] data,
                            logic poll);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {6'b0, poll, data, addr};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        tracker.note_command(code, addr, data, poll);
        burst_left = burst_left - 1;
    endtask

    // Hold the sender until every expected byte has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.pending() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int          sent;
        logic [3:0]  code;
        logic [24:0] addr;
        logic [7:0]  window;
        int          pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cmd(spfb_pkg::CMD_ENTER_PROG, 25'h0, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_CHIP_ERASE, 25'h1FFFFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_FUSE_LOW, 25'h0, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_FUSE_HIGH, 25'h1FFFFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_READ_EEPROM, 25'h0, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_WRITE_EEP, 25'h000FFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_WRITE_EEP, 25'h1FFFFFF, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_READ_EEPROM, 25'h1FFFFFF, 8'hFF, 1'b1);
        // flash in window zero: no extended frame yet
        send_cmd(spfb_pkg::CMD_READ_FLASH, 25'h0, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_READ_FLASH, 25'h0000001, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_LOAD_FLASH, 25'h001FFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_WRITE_PAGE, 25'h001FFFE, 8'h00, 1'b0);
        // top window, then stay in it
        send_cmd(spfb_pkg::CMD_LOAD_FLASH, 25'h1FFFFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_LOAD_FLASH, 25'h1FE0000, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_WRITE_PAGE, 25'h1FFFFFE, 8'hA5, 1'b1);
        // non-flash commands leave the window alone
        send_cmd(spfb_pkg::CMD_READ_EEPROM, 25'h0000000, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_READ_FLASH, 25'h1FFFFFF, 8'h00, 1'b0);
        // unused codes are dropped and must not disturb the window
        send_cmd(4'd9, 25'h0, 8'h00, 1'b0);
        send_cmd(4'd15, 25'h1FFFFFF, 8'hFF, 1'b1);
        send_cmd(spfb_pkg::CMD_WRITE_PAGE, 25'h0000000, 8'h00, 1'b1);
        send_cmd(spfb_pkg::CMD_READ_FLASH, 25'h0020000, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_READ_FLASH, 25'h0020001, 8'h00, 1'b0);
        send_cmd(spfb_pkg::CMD_ENTER_PROG, 25'h1FFFFFF, 8'hFF, 1'b1);

        sent   = 0;
        window = 8'h00;
        while (sent < RANDOM_CMDS) begin
            if (sent == 40)
                hold_req = 1'b1;
            if (sent == 90)
                wait_drained();
            pick = $urandom_range(0, 99);
            addr = 25'($urandom_range(0, 33554431));
            if (pick < 70) begin
                code = 4'($urandom_range(spfb_pkg::CMD_READ_FLASH, spfb_pkg::CMD_WRITE_PAGE));
                // mostly stay in a window, moving now and then
                if ($urandom_range(0, 4) == 0)
                    window = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0)
                    addr[24:spfb_pkg::EXT_LSB] = window;
            end else if (pick < 94) begin
                code = 4'($urandom_range(spfb_pkg::CMD_READ_EEPROM, spfb_pkg::CMD_ENTER_PROG));
            end else begin
                code = 4'($urandom_range(9, 15));
            end
            send_cmd(code, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if (code <= spfb_pkg::CMD_ENTER_PROG)
                sent++;
        end
        s_axis_tvalid <= 1'b0;

        while (tracker.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
